@@ rtl/core/gf256_arithmetic_unit_top_macros.svh @@
// ----------------------------------------------------------------------------
// gf256 arithmetic unit assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset rst_ni
// ----------------------------------------------------------------------------
`ifndef GF256_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_TOP_MACROS_SVH

// property checked only while out of reset
`define GFAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every edge, reset included
`define GFAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/gfau_pkg.sv @@
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, constants and log/exp tables for GF(2^8), polynomial 0x11d
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfau_pkg;

  // field constants
  localparam logic [8:0] FIELD_POLY  = 9'h11d;
  localparam logic [8:0] FIELD_TOP   = 9'h100;
  localparam logic [7:0] GROUP_ORDER = 8'd255;

  typedef logic [7:0] gf_t;
  typedef logic [255:0][7:0] rom_t;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_INV = 2'd1,
    CMD_POW = 2'd2
  } cmd_e;

  // after the log stage
  typedef struct packed {
    cmd_e cmd;
    gf_t  log_a;
    gf_t  opnd;     // log of b, or raw exponent for power
    logic fix_en;   // result fixed by a special case (zero operand, zero exponent or unused command)
    gf_t  fix_val;
  } s1_t;

  // after the product stage
  typedef struct packed {
    logic [15:0] prod;
    logic        fix_en;
    gf_t         fix_val;
  } s2_t;

  // after the modulo fold
  typedef struct packed {
    gf_t  idx;
    logic fix_en;
    gf_t  fix_val;
  } s3_t;

  // powers of the generator, evaluated at elaboration
  function automatic rom_t build_exp();
    rom_t       t;
    logic [8:0] p;
    p = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = p[7:0];
      p    = {p[7:0], 1'b0};
      if ((p & FIELD_TOP) != '0) begin
        p = p ^ FIELD_POLY;
      end
    end
    return t;
  endfunction

  // discrete log, entry for zero unused
  function automatic rom_t build_log();
    rom_t e;
    rom_t t;
    e = build_exp();
    t = '0;
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam rom_t EXP_ROM = build_exp();
  localparam rom_t LOG_ROM = build_log();

endpackage

`default_nettype wire

@@ rtl/core/gfau_if.sv @@
// ----------------------------------------------------------------------------
// gfau channel interfaces
// Valid/ready channels for command items and result bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gfau_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

interface gfau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gf256_arithmetic_unit_top.sv @@
// GF(2^8) arithmetic unit, polynomial 0x11d, generator 2.
// Input channel in_i carries command (0 multiply, 1 inverse, 2 power),
// operand_a and operand_b; output channel out_o carries one result byte
// per input item, in order. A transfer happens when valid and ready are
// both high at a rising edge of clk_i.
// Each item passes four register stages in order: log lookup, log
// sum/product, modulo-255 fold, exp lookup into the output register.
// Throughput: one item per cycle while out_o.ready is high, set by the
// four register stages each taking a new item every clock unless the
// stall described below holds them.
// Command 3 yields 0. Power with exponent 0 yields 1, zero base yields 0.
// Reset (rst_ni low, asynchronous) empties every stage and holds in_i.ready
// low; the unit takes items once rst_ni is released.
// When the receiver holds ready low the stall walks back one stage per
// full stage: empty stages still fill, so in_i.ready only drops once all
// four stages hold an item.
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_top
// Four-stage pipelined GF(2^8) multiply, inverse and power unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf256_arithmetic_unit_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gfau_in_if.sink     in_i,
  gfau_out_if.source  out_o
);
  import gfau_pkg::*;

  s1_t  s1;
  logic s1_valid;
  logic s1_ready;
  s3_t  s3;
  logic s3_valid;
  logic s3_ready;

  // log lookups
  gfau_log_stage u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .s1_o    (s1),
    .valid_o (s1_valid),
    .ready_i (s1_ready)
  );

  // exponent arithmetic
  gfau_index_stage u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s1_i    (s1),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .s3_o    (s3),
    .valid_o (s3_valid),
    .ready_i (s3_ready)
  );

  // exp lookup and output register
  gfau_exp_stage u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s3_i    (s3),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/gfau_log_stage.sv @@
// ----------------------------------------------------------------------------
// gfau_log_stage
// First stage: log lookups and zero special cases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfau_log_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  gfau_in_if.sink           in_i,
  output gfau_pkg::s1_t     s1_o,
  output logic              valid_o,
  input  wire logic         ready_i
);
  import gfau_pkg::*;

  cmd_e cmd;
  gf_t  op_a;
  gf_t  op_b;
  s1_t  s1_d;
  s1_t  s1_q;
  logic valid_q;
  logic take;

  assign cmd  = cmd_e'(in_i.command);
  assign op_a = in_i.operand_a;
  assign op_b = in_i.operand_b;

  // stage handshake, closed while in reset
  assign in_i.ready = rst_ni && (!valid_q || ready_i);
  assign take       = in_i.valid && in_i.ready;

  // lookups and special cases
  always_comb begin
    s1_d.cmd     = cmd;
    s1_d.log_a   = LOG_ROM[op_a];
    s1_d.opnd    = (cmd == CMD_POW) ? op_b : LOG_ROM[op_b];
    s1_d.fix_en  = 1'b0;
    s1_d.fix_val = '0;
    unique case (cmd)
      CMD_MUL: begin
        s1_d.fix_en = (op_a == '0) || (op_b == '0);
      end
      CMD_INV: begin
        s1_d.fix_en = (op_a == '0);
      end
      CMD_POW: begin
        if (op_b == '0) begin
          s1_d.fix_en  = 1'b1;
          s1_d.fix_val = 8'd1;
        end else begin
          s1_d.fix_en = (op_a == '0);
        end
      end
      default: begin
        s1_d.fix_en = 1'b1;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o    = s1_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/gfau_index_stage.sv @@
// ----------------------------------------------------------------------------
// gfau_index_stage
// Second and third stages: log sum/product, then fold modulo 255
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gf256_arithmetic_unit_top_macros.svh"

module gfau_index_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gfau_pkg::s1_t s1_i,
  input  wire logic         valid_i,
  output logic              ready_o,
  output gfau_pkg::s3_t     s3_o,
  output logic              valid_o,
  input  wire logic         ready_i
);
  import gfau_pkg::*;

  s2_t        s2_d;
  s2_t        s2_q;
  logic       v2_q;
  logic       rdy2;
  s3_t        s3_d;
  s3_t        s3_q;
  logic       v3_q;
  logic       rdy3;
  logic [8:0] fold;

  // handshake chain
  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  // exponent before reduction
  always_comb begin
    s2_d.fix_en  = s1_i.fix_en;
    s2_d.fix_val = s1_i.fix_val;
    unique case (s1_i.cmd)
      CMD_MUL: s2_d.prod = 16'(s1_i.log_a) + 16'(s1_i.opnd);
      CMD_INV: s2_d.prod = 16'(GROUP_ORDER - s1_i.log_a);
      CMD_POW: s2_d.prod = 16'(s1_i.log_a) * 16'(s1_i.opnd);
      default: s2_d.prod = '0;
    endcase
  end

  // modulo 255 by folding, since 256 is 1 mod 255
  always_comb begin
    fold         = {1'b0, s2_q.prod[15:8]} + {1'b0, s2_q.prod[7:0]};
    s3_d.fix_en  = s2_q.fix_en;
    s3_d.fix_val = s2_q.fix_val;
    if (fold >= {1'b0, GROUP_ORDER}) begin
      s3_d.idx = 8'(fold - {1'b0, GROUP_ORDER});
    end else begin
      s3_d.idx = fold[7:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o    = s3_q;
  assign valid_o = v3_q;

  // checks
  `GFAU_ASSERT(a_s2_hold, v2_q && !rdy3 |=> v2_q, "product stage lost an item")
  `GFAU_ASSERT(a_s3_hold,
               v3_q && !ready_i |=> v3_q && $stable(s3_q),
               "fold stage lost an item")
  `GFAU_ASSERT(a_idx_range, v3_q |-> s3_q.idx <= GROUP_ORDER, "index past group order")
  `GFAU_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !v2_q && !v3_q, "stages not empty after reset")

endmodule

`default_nettype wire

@@ rtl/core/gfau_exp_stage.sv @@
// ----------------------------------------------------------------------------
// gfau_exp_stage
// Last stage: exp lookup, special-case select and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gf256_arithmetic_unit_top_macros.svh"

module gfau_exp_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gfau_pkg::s3_t s3_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  gfau_out_if.source         out_o
);
  import gfau_pkg::*;

  gf_t  result_d;
  gf_t  result_q;
  logic valid_q;
  logic take;

  assign ready_o = !valid_q || out_o.ready;
  assign take    = valid_i && ready_o;

  // table lookup unless a special case fixed the value
  assign result_d = s3_i.fix_en ? s3_i.fix_val : EXP_ROM[s3_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.result = result_q;

  // checks
  `GFAU_ASSERT(a_fix_pass,
               take && s3_i.fix_en |=> result_q == $past(s3_i.fix_val),
               "special case value lost")
  `GFAU_ASSERT(a_exp_wrap,
               take && !s3_i.fix_en && (s3_i.idx == '0 || s3_i.idx == GROUP_ORDER)
                 |=> result_q == 8'd1,
               "exp table wrap wrong")
  `GFAU_ASSERT_ALWAYS(a_rst_out, !rst_ni |=> !valid_q, "output valid after reset")

endmodule

`default_nettype wire

@@ test/tb_gf256_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf256_arithmetic_unit_top
// Self-checking bench for the GF(2^8) multiply, inverse and power unit.
// A local predictor computes each result byte from the accepted command and
// operands; a monitor compares every output transfer against the oldest
// prediction. Directed corner items come first, then random traffic with
// random gaps on both channels, a back-to-back stretch and a long output hold.
// ----------------------------------------------------------------------------

module tb_gf256_arithmetic_unit_top;
  import gfau_pkg::*;

  localparam int         CLK_PERIOD  = 4;
  localparam int         RESET_LEN   = 12;
  localparam int         DRAIN_WAIT  = 8;
  localparam int         HOLD_CYCLES = 60;
  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  gfau_in_if  in_ch ();
  gfau_out_if out_ch ();

  gf256_arithmetic_unit_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // bench state
  gf_t predicted_results[$];
  int  fail_count   = 0;
  int  checked      = 0;
  int  cycle_count  = 0;
  int  cmd_count[4] = '{default: 0};
  bit  src_idle_on  = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  hold_req     = 1'b0;

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // shift-and-add product, reduced by the field polynomial
  function automatic gf_t field_product(input gf_t x, input gf_t y);
    logic [8:0] p;
    gf_t        acc;
    acc = '0;
    p   = {1'b0, x};
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc ^= p[7:0];
      end
      p = p << 1;
      if (p[8]) begin
        p ^= FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // square-and-multiply over the eight exponent bits
  function automatic gf_t field_raise(input gf_t base, input gf_t expo);
    gf_t acc;
    gf_t sq;
    acc = 8'd1;
    sq  = base;
    for (int k = 0; k < 8; k++) begin
      if (expo[k]) begin
        acc = field_product(acc, sq);
      end
      sq = field_product(sq, sq);
    end
    return acc;
  endfunction

  function automatic gf_t predict_field_result(input logic [1:0] c, input gf_t a,
                                               input gf_t b);
    case (c)
      CMD_MUL: begin
        return field_product(a, b);
      end
      CMD_INV: begin
        // inverse is a^(order-1); zero maps to zero
        return (a == '0) ? '0 : field_raise(a, GROUP_ORDER - 8'd1);
      end
      CMD_POW: begin
        if (b == '0) begin
          return 8'd1;
        end
        if (a == '0) begin
          return '0;
        end
        return field_raise(a, b);
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int long_lo, input int long_hi);
    if ($urandom_range(0, 99) < 75) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(long_lo, long_hi);
  endfunction

  // operands biased towards zero, one and all-ones
  function automatic gf_t pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hff;
      default: return gf_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) begin
      return CMD_MUL;
    end
    if (r < 64) begin
      return CMD_INV;
    end
    if (r < 97) begin
      return CMD_POW;
    end
    return CMD_UNUSED;
  endfunction

  // offer one item, hold it until the transfer, then log the prediction
  task automatic send_op(input logic [1:0] c, input gf_t a, input gf_t b);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 99) < 35) begin
      gap = pick_gap(6, 30);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predicted_results.push_back(predict_field_result(c, a, b));
    cmd_count[c]++;
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  task automatic test_corner_cases();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    // multiply: zero operands and extremes
    send_op(CMD_MUL, 8'h00, 8'h00);
    send_op(CMD_MUL, 8'h00, 8'hff);
    send_op(CMD_MUL, 8'hff, 8'h00);
    send_op(CMD_MUL, 8'h01, 8'hff);
    send_op(CMD_MUL, 8'hff, 8'hff);
    send_op(CMD_MUL, 8'h80, 8'h02);
    send_op(CMD_MUL, 8'h02, 8'h80);
    // inverse: zero, one and operand b ignored
    send_op(CMD_INV, 8'h00, 8'h00);
    send_op(CMD_INV, 8'h01, 8'hff);
    send_op(CMD_INV, 8'h02, 8'h00);
    send_op(CMD_INV, 8'hff, 8'h55);
    // power: zero exponent, zero base, large exponents
    send_op(CMD_POW, 8'h00, 8'h00);
    send_op(CMD_POW, 8'hff, 8'h00);
    send_op(CMD_POW, 8'h00, 8'h01);
    send_op(CMD_POW, 8'h00, 8'hff);
    send_op(CMD_POW, 8'h02, 8'hff);
    send_op(CMD_POW, 8'h03, 8'hfe);
    send_op(CMD_POW, 8'hff, 8'hff);
    send_op(CMD_POW, 8'h1d, 8'h01);
    // unused command code
    send_op(CMD_UNUSED, 8'h00, 8'h00);
    send_op(CMD_UNUSED, 8'hff, 8'hff);
    send_op(CMD_UNUSED, 8'h5a, 8'ha5);
  endtask

  task automatic test_random_traffic(input int n);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int i = 0; i < n; i++) begin
      send_op(pick_command(), pick_byte(), pick_byte());
    end
  endtask

  task automatic test_back_to_back(input int n);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < n; i++) begin
      send_op(pick_command(), gf_t'($urandom_range(0, 255)), gf_t'($urandom_range(0, 255)));
    end
  endtask

  // output held off while items keep coming, so the pipe fills and stalls
  task automatic test_output_hold(input int n);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_req     = 1'b1;
    for (int i = 0; i < n; i++) begin
      send_op(pick_command(), pick_byte(), pick_byte());
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_MUL;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_traffic(1250);
    test_back_to_back(300);
    test_output_hold(40);
    test_random_traffic(60);
    in_ch.valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d items: %0d multiply, %0d inverse, %0d power, %0d unused code",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("%0d results checked, with random gaps, a back-to-back run and a %0d-cycle hold",
             checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_gf256_arithmetic_unit_top: PASS");
    end else begin
      $display("tb_gf256_arithmetic_unit_top: FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // receiver ready: random stalls, plus the long hold on request
  // ------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap(10, 40)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ------------------------------------------------------------------
  // result monitor
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with nothing outstanding: actual %02h", out_ch.result);
        fail_count++;
      end else begin
        if (out_ch.result !== predicted_results[0]) begin
          $error("result mismatch: expected %02h, actual %02h",
                 predicted_results[0], out_ch.result);
          fail_count++;
        end
        void'(predicted_results.pop_front());
        checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("tb_gf256_arithmetic_unit_top: FAIL");
      $finish;
    end
  end

endmodule
